// ----- src/cfsp_pkg.sv -----
// Shared types and constants for the clock synthesizer frequency planner.
`timescale 1ns / 1ps

package cfsp_pkg;

  // Shared divider geometry
  localparam int unsigned DvdW = 48;
  localparam int unsigned DvsW = 32;

  // Request transaction
  typedef struct packed {
    logic               transmit;
    logic [25:0]        lo_hz;
    logic signed [15:0] rit_hz;
  } in_item_t;

  // Register write transaction
  typedef struct packed {
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic        last;
    logic        soft_update;
    logic [10:0] divider;
    logic        error;
  } out_item_t;

  // Configuration register indexes
  localparam logic [1:0] CfgPitch      = 2'd0;
  localparam logic [1:0] CfgPpmWhole   = 2'd1;
  localparam logic [1:0] CfgPpmHundred = 2'd2;
  localparam logic [1:0] CfgXtal       = 2'd3;

  // Frequency plan limits
  localparam logic [39:0] VcoMin    = 40'd600000000;
  localparam logic [39:0] VcoMax    = 40'd900000000;
  localparam logic [31:0] VcoCenter = 32'd750000000;
  localparam logic [10:0] MsMin     = 11'd6;
  localparam logic [10:0] MsMax     = 11'd1800;
  localparam logic [19:0] FracDen   = 20'd1048575;
  localparam logic [7:0]  MultMin   = 8'd15;
  localparam logic [7:0]  MultMax   = 8'd90;

  // ppm scaling: 4*base*P/1e8 = ((base*P) >> 6) / 390625
  localparam logic [18:0] PpmDiv    = 19'd390625;
  // floor(2^34 / 390625), estimate that is low by at most two
  localparam logic [15:0] PpmRecip  = 16'd43980;

  // Synthesizer register map
  localparam logic [7:0] RegClk0     = 8'd16;
  localparam logic [7:0] RegPllA     = 8'd26;
  localparam logic [7:0] RegMs0      = 8'd42;
  localparam logic [7:0] RegPllReset = 8'd177;
  localparam logic [7:0] ClkOff      = 8'h80;
  localparam logic [7:0] ClkOn       = 8'h4F;
  localparam logic [7:0] PllResetVal = 8'hA0;

endpackage

// ----- src/clock_synth_frequency_planner.sv -----
// Top level: configuration registers, sequencer and register write stream.
`timescale 1ns / 1ps

// Each request is worked by a small sequencer around one 48-bit restoring
// divider and one 30x14 multiplier; the ppm correction uses a reciprocal
// estimate with a small fix-up and the PLL fraction split uses shift-and-add
// logic. A zero target skips the divisions and gives one error write; a hard
// retune whose soft check and first divider choice both fail takes six
// divisions before its writes. A request delivers 9 register writes for a
// soft update and 19 for a hard retune. The input stalls for the whole
// request; the last write may still wait in the output register while the
// next request is taken.

module clock_synth_frequency_planner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cfsp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfsp_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cfsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PROD, S_PPM_EST, S_PPM_WT, S_CHK, S_SOFT_WT, S_SOFT_MUL, S_SOFT_CHK,
    S_SOFT_DV, S_HARD, S_HARD_WT, S_HARD_MUL, S_HARD_CHK, S_FB_WT, S_FB_MUL,
    S_FIN, S_FIN_WT, S_NUM, S_NUM_WT, S_Q, S_EMIT, S_ERR
  } state_e;

  // Write stream steps (hard order; soft walks the PLL steps then clock on)
  localparam logic [4:0] StepClkOff   = 5'd0;
  localparam logic [4:0] StepPllFirst = 5'd1;
  localparam logic [4:0] StepPllLast  = 5'd8;
  localparam logic [4:0] StepMsFirst  = 5'd9;
  localparam logic [4:0] StepMsLast   = 5'd16;
  localparam logic [4:0] StepReset    = 5'd17;
  localparam logic [4:0] StepClkOn    = 5'd18;

  // Configuration registers
  logic [11:0] pitch_q;
  logic [7:0]  ppm_whole_q, ppm_hund_q;
  logic [25:0] xtal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q     <= 12'd700;
      ppm_whole_q <= '0;
      ppm_hund_q  <= '0;
      xtal_q      <= 26'd25000000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        CfgPitch:      pitch_q     <= pwdata[11:0];
        CfgPpmWhole:   ppm_whole_q <= pwdata[7:0];
        CfgPpmHundred: ppm_hund_q  <= pwdata[7:0];
        CfgXtal:       xtal_q      <= pwdata[25:0];
        default:       pitch_q     <= pitch_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CfgPitch:      prdata = {20'd0, pitch_q};
      CfgPpmWhole:   prdata = {24'd0, ppm_whole_q};
      CfgPpmHundred: prdata = {24'd0, ppm_hund_q};
      CfgXtal:       prdata = {6'd0, xtal_q};
      default:       prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Combined ppm correction, 100*whole + hundredths, as sign and magnitude
  logic signed [15:0] pw_ext, ph_ext, ppm_s, ppm_neg_s;
  logic               ppm_neg;
  logic [13:0]        ppm_mag;
  logic [25:0]        xt;

  assign pw_ext    = 16'(signed'(ppm_whole_q));
  assign ph_ext    = 16'(signed'(ppm_hund_q));
  assign ppm_s     = (pw_ext <<< 6) + (pw_ext <<< 5) + (pw_ext <<< 2) + ph_ext;
  assign ppm_neg   = ppm_s[15];
  assign ppm_neg_s = -ppm_s;
  assign ppm_mag   = ppm_neg ? ppm_neg_s[13:0] : ppm_s[13:0];
  assign xt        = (xtal_q == '0) ? 26'd1 : xtal_q;

  // Request base frequency, negative saturates to zero
  logic signed [27:0] base_s;
  logic [26:0]        base_in;

  assign base_s = in_data_i.transmit
                ? signed'({2'b00, in_data_i.lo_hz}) + signed'({16'd0, pitch_q})
                : signed'({2'b00, in_data_i.lo_hz}) + 28'(in_data_i.rit_hz);
  assign base_in = base_s[27] ? '0 : base_s[26:0];

  // Sequencer state and datapath registers
  state_e      state_q;
  logic [26:0] base_q;
  logic [39:0] prod_q;
  logic [15:0] q0_q;
  logic [29:0] target_q;
  logic [39:0] pll_q;
  logic [10:0] div_q, held_q;
  logic        soft_q;
  logic [7:0]  mult_q;
  logic [25:0] rem_q;
  logic [19:0] num_q;
  logic [17:0] p1_q;
  logic [19:0] p2_q;
  logic [4:0]  step_q;
  logic        out_valid_q;
  out_item_t   out_q;

  // Shared multiplier
  logic [29:0] mul_a;
  logic [13:0] mul_b;
  logic [43:0] mul_p;

  assign mul_a = (state_q == S_PROD) ? {3'b000, base_q} : target_q;
  assign mul_b = (state_q == S_PROD) ? ppm_mag : {3'b000, div_q};
  assign mul_p = mul_a * mul_b;

  // ppm quotient: reciprocal estimate, then fix-up of at most two
  logic [31:0] est_p;
  logic [34:0] qd_p, ppm_rem;
  logic [15:0] ppm_q;

  assign est_p   = 32'(prod_q[39:24]) * 32'(PpmRecip);
  assign qd_p    = 35'(q0_q) * 35'(PpmDiv);
  assign ppm_rem = {1'b0, prod_q[39:6]} - qd_p;

  always_comb begin
    if (ppm_rem >= {15'd0, PpmDiv, 1'b0})  ppm_q = q0_q + 16'd2;
    else if (ppm_rem >= {16'd0, PpmDiv})   ppm_q = q0_q + 16'd1;
    else                                   ppm_q = q0_q;
  end

  // Fraction split of 128*num by 2^20-1: high bits fold into the low bits
  logic [20:0] frac_s;
  logic [7:0]  frac_q8;
  logic [19:0] frac_r;

  assign frac_s = {14'd0, num_q[19:13]} + {1'b0, num_q[12:0], 7'd0};

  always_comb begin
    if (frac_s >= {1'b0, FracDen}) begin
      frac_q8 = {1'b0, num_q[19:13]} + 8'd1;
      frac_r  = 20'(frac_s - {1'b0, FracDen});
    end else begin
      frac_q8 = {1'b0, num_q[19:13]};
      frac_r  = frac_s[19:0];
    end
  end

  // Shared divider hookup
  logic            div_start, div_done;
  logic [DvdW-1:0] div_dvd, div_quo;
  logic [DvsW-1:0] div_dvs, div_rem;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 32'd1;
    unique case (state_q)
      S_CHK: begin
        div_start = held_q >= MsMin;
        div_dvd   = {8'd0, VcoMax};
        div_dvs   = {21'd0, held_q};
      end
      S_SOFT_CHK: begin
        div_start = pll_q >= VcoMin;
        div_dvd   = {8'd0, pll_q};
        div_dvs   = {6'd0, xt};
      end
      S_HARD: begin
        div_start = 1'b1;
        div_dvd   = {16'd0, VcoCenter};
        div_dvs   = {2'b00, target_q};
      end
      S_HARD_CHK: begin
        div_start = (pll_q > VcoMax) || (pll_q < VcoMin);
        div_dvd   = {8'd0, VcoMax};
        div_dvs   = {2'b00, target_q};
      end
      S_FIN: begin
        div_start = 1'b1;
        div_dvd   = {8'd0, pll_q};
        div_dvs   = {6'd0, xt};
      end
      S_NUM: begin
        div_start = 1'b1;
        div_dvd   = {2'b00, rem_q, 20'd0} - {22'd0, rem_q};
        div_dvs   = {6'd0, xt};
      end
      default: div_start = 1'b0;
    endcase
  end

  cfsp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Divider choices for a hard retune
  logic [10:0] hard_div, fb_div, fb_cap;
  logic [29:0] target_d;
  logic [15:0] dmag;

  always_comb begin
    if (div_quo < DvdW'(MsMin))      hard_div = MsMin;
    else if (div_quo > DvdW'(MsMax)) hard_div = MsMax;
    else                             hard_div = div_quo[10:0];
    hard_div = {hard_div[10:1], 1'b0};

    fb_cap = (div_quo > DvdW'(MsMax)) ? MsMax : div_quo[10:0];
    fb_cap = {fb_cap[10:1], 1'b0};
    fb_div = (fb_cap < MsMin) ? MsMin : fb_cap;

    dmag     = {ppm_q[15:2], 2'b00};
    target_d = ppm_neg ? {1'b0, base_q, 2'b00} + {14'd0, dmag}
                       : {1'b0, base_q, 2'b00} - {14'd0, dmag};
  end

  // Byte of a PLL or multisynth parameter block
  function automatic logic [7:0] blk_byte(input logic [2:0] b, input logic [17:0] p1,
                                         input logic [19:0] p2, input logic [19:0] p3);
    logic [7:0] r;
    unique case (b)
      3'd0:    r = p3[15:8];
      3'd1:    r = p3[7:0];
      3'd2:    r = {6'd0, p1[17:16]};
      3'd3:    r = p1[15:8];
      3'd4:    r = p1[7:0];
      3'd5:    r = {p3[19:16], p2[19:16]};
      3'd6:    r = p2[15:8];
      default: r = p2[7:0];
    endcase
    return r;
  endfunction

  // Next write of the stream
  logic [17:0] ms_p1;
  logic [2:0]  pll_b, ms_b;
  out_item_t   emit_item, err_item;
  logic        out_free;

  assign ms_p1 = {div_q, 7'd0} - 18'd512;
  assign pll_b = 3'(step_q - StepPllFirst);
  assign ms_b  = 3'(step_q - StepMsFirst);

  always_comb begin
    emit_item             = '0;
    emit_item.soft_update = soft_q;
    emit_item.divider     = div_q;
    emit_item.last        = step_q == StepClkOn;
    if (step_q == StepClkOff) begin
      emit_item.reg_addr = RegClk0;
      emit_item.reg_data = ClkOff;
    end else if (step_q <= StepPllLast) begin
      emit_item.reg_addr = RegPllA + {5'd0, pll_b};
      emit_item.reg_data = blk_byte(pll_b, p1_q, p2_q, FracDen);
    end else if (step_q <= StepMsLast) begin
      emit_item.reg_addr = RegMs0 + {5'd0, ms_b};
      emit_item.reg_data = blk_byte(ms_b, ms_p1, 20'd0, 20'd1);
    end else if (step_q == StepReset) begin
      emit_item.reg_addr = RegPllReset;
      emit_item.reg_data = PllResetVal;
    end else begin
      emit_item.reg_addr = RegClk0;
      emit_item.reg_data = ClkOn;
    end
    err_item       = '0;
    err_item.last  = 1'b1;
    err_item.error = 1'b1;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      soft_q      <= 1'b0;
      step_q      <= '0;
    end else begin
      if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            base_q  <= base_in;
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          prod_q  <= mul_p[39:0];
          state_q <= S_PPM_EST;
        end
        S_PPM_EST: begin
          q0_q    <= est_p[31:16];
          state_q <= S_PPM_WT;
        end
        S_PPM_WT: begin
          target_q <= target_d;
          state_q  <= (target_d == '0) ? S_ERR : S_CHK;
        end
        S_CHK: begin
          soft_q  <= 1'b0;
          div_q   <= held_q;
          state_q <= (held_q >= MsMin) ? S_SOFT_WT : S_HARD;
        end
        S_SOFT_WT: begin
          if (div_done) begin
            state_q <= ({18'd0, target_q} <= div_quo) ? S_SOFT_MUL : S_HARD;
          end
        end
        S_SOFT_MUL: begin
          pll_q   <= mul_p[39:0];
          state_q <= S_SOFT_CHK;
        end
        S_SOFT_CHK: state_q <= (pll_q >= VcoMin) ? S_SOFT_DV : S_HARD;
        S_SOFT_DV: begin
          if (div_done) begin
            if (div_quo[7:0] >= MultMin && div_quo[7:0] <= MultMax) begin
              soft_q  <= 1'b1;
              state_q <= S_FIN;
            end else begin
              state_q <= S_HARD;
            end
          end
        end
        S_HARD: state_q <= S_HARD_WT;
        S_HARD_WT: begin
          if (div_done) begin
            div_q   <= hard_div;
            state_q <= S_HARD_MUL;
          end
        end
        S_HARD_MUL: begin
          pll_q   <= mul_p[39:0];
          state_q <= S_HARD_CHK;
        end
        S_HARD_CHK: begin
          state_q <= ((pll_q > VcoMax) || (pll_q < VcoMin)) ? S_FB_WT : S_FIN;
        end
        S_FB_WT: begin
          if (div_done) begin
            div_q   <= fb_div;
            state_q <= S_FB_MUL;
          end
        end
        S_FB_MUL: begin
          pll_q   <= mul_p[39:0];
          state_q <= S_FIN;
        end
        S_FIN: state_q <= S_FIN_WT;
        S_FIN_WT: begin
          if (div_done) begin
            mult_q  <= div_quo[7:0];
            rem_q   <= div_rem[25:0];
            state_q <= S_NUM;
          end
        end
        S_NUM: state_q <= S_NUM_WT;
        S_NUM_WT: begin
          if (div_done) begin
            num_q   <= div_quo[19:0];
            state_q <= S_Q;
          end
        end
        S_Q: begin
          p1_q    <= {3'd0, mult_q, 7'd0} + {10'd0, frac_q8} - 18'd512;
          p2_q    <= frac_r;
          held_q  <= div_q;
          step_q  <= soft_q ? StepPllFirst : StepClkOff;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= emit_item;
            out_valid_q <= 1'b1;
            if (step_q == StepClkOn) begin
              state_q <= S_IDLE;
            end else if (soft_q && step_q == StepPllLast) begin
              step_q <= StepClkOn;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_q       <= err_item;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/cfsp_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cfsp_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cfsp_pkg::DvdW-1:0] dividend_i,
  input  logic [cfsp_pkg::DvsW-1:0] divisor_i,
  output logic                      done_o,
  output logic [cfsp_pkg::DvdW-1:0] quo_o,
  output logic [cfsp_pkg::DvsW-1:0] rem_o
);
  import cfsp_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q, quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvsW:0]   trial;
  logic            fits;

  // Trial subtraction of the next partial remainder
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      quo_q <= {quo_q[DvdW-2:0], fits};
      rem_q <= fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- verif/cfsp_checker.sv -----
// Checker for the frequency planner: predicts register write streams and compares them.
`timescale 1ns / 1ps

module cfsp_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  cfsp_pkg::in_item_t   in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  cfsp_pkg::out_item_t  out_data_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import cfsp_pkg::*;

  // Shadow configuration and held divider
  logic [11:0] pitch_q;
  logic [7:0]  ppm_whole_q;
  logic [7:0]  ppm_hund_q;
  logic [25:0] xtal_q;
  logic [10:0] held_div_q;

  out_item_t writes_q[$];

  assign pending_o = writes_q.size();

  function automatic out_item_t mk(logic [7:0] a, logic [7:0] d, logic sf, logic [10:0] dv);
    out_item_t o;
    o = '0;
    o.reg_addr = a;
    o.reg_data = d;
    o.soft_update = sf;
    o.divider = dv;
    return o;
  endfunction

  // Queue the eight bytes of one PLL or multisynth parameter block
  task automatic push_block(logic [7:0] a, longint unsigned p1, longint unsigned p2,
                            longint unsigned p3, logic sf, logic [10:0] dv);
    writes_q.push_back(mk(a,         8'((p3 >> 8) & 255), sf, dv));
    writes_q.push_back(mk(a + 8'd1,  8'(p3 & 255), sf, dv));
    writes_q.push_back(mk(a + 8'd2,  8'((p1 >> 16) & 3), sf, dv));
    writes_q.push_back(mk(a + 8'd3,  8'((p1 >> 8) & 255), sf, dv));
    writes_q.push_back(mk(a + 8'd4,  8'(p1 & 255), sf, dv));
    writes_q.push_back(mk(a + 8'd5,  8'((((p3 >> 16) & 15) << 4) | ((p2 >> 16) & 15)), sf, dv));
    writes_q.push_back(mk(a + 8'd6,  8'((p2 >> 8) & 255), sf, dv));
    writes_q.push_back(mk(a + 8'd7,  8'(p2 & 255), sf, dv));
  endtask

  // Frequency plan for one request
  task automatic plan_request(in_item_t r);
    longint base, ppm, delta;
    longint unsigned tgt, pll, xt, dv, mult, rem, num, q, p1, p2;
    logic soft_hit;
    out_item_t e;
    soft_hit = 1'b0;
    base = r.transmit ? longint'(r.lo_hz) + longint'(pitch_q)
                      : longint'(r.lo_hz) + longint'(r.rit_hz);
    if (base < 0) base = 0;
    ppm = 100 * longint'($signed(ppm_whole_q)) + longint'($signed(ppm_hund_q));
    delta = -((4 * base * ppm) / 100000000);
    delta = delta - (delta % 4);
    tgt = unsigned'(4 * base + delta);
    if (tgt == 0) begin
      e = '0;
      e.last = 1'b1;
      e.error = 1'b1;
      writes_q.push_back(e);
      return;
    end
    xt = (xtal_q == 0) ? 1 : xtal_q;
    if (held_div_q >= 6 && tgt <= 900000000 / held_div_q) begin
      pll = held_div_q * tgt;
      if (pll >= 600000000) begin
        mult = (pll / xt) & 255;
        if (mult >= 15 && mult <= 90) soft_hit = 1'b1;
      end
    end
    if (soft_hit) begin
      dv = held_div_q;
    end else begin
      dv = 750000000 / tgt;
      if (dv < 6) dv = 6;
      if (dv > 1800) dv = 1800;
      dv = dv & ~64'd1;
      if (dv < 6) dv = 6;
      pll = dv * tgt;
      if (pll > 900000000 || pll < 600000000) begin
        dv = 900000000 / tgt;
        if (dv > 1800) dv = 1800;
        dv = dv & ~64'd1;
        if (dv < 6) dv = 6;
      end
    end
    pll = dv * tgt;
    mult = (pll / xt) & 255;
    rem = pll % xt;
    num = (rem * 1048575) / xt;
    q = (128 * num) / 1048575;
    p1 = (128 * mult + q - 512) & 64'hFFFF_FFFF;
    p2 = 128 * num - 1048575 * q;
    if (!soft_hit) writes_q.push_back(mk(RegClk0, ClkOff, soft_hit, 11'(dv)));
    push_block(RegPllA, p1, p2, 1048575, soft_hit, 11'(dv));
    if (!soft_hit) begin
      push_block(RegMs0, (128 * dv - 512) & 64'hFFFF_FFFF, 0, 1, soft_hit, 11'(dv));
      writes_q.push_back(mk(RegPllReset, PllResetVal, soft_hit, 11'(dv)));
    end
    e = mk(RegClk0, ClkOn, soft_hit, 11'(dv));
    e.last = 1'b1;
    writes_q.push_back(e);
    held_div_q = 11'(dv);
  endtask

  // Track config, predict on input transactions, compare output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      pitch_q <= 12'd700;
      ppm_whole_q <= '0;
      ppm_hund_q <= '0;
      xtal_q <= 26'd25000000;
      held_div_q = '0;
      fail_count_o <= 0;
      writes_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPitch:      pitch_q <= cfg_wdata_i[11:0];
          CfgPpmWhole:   ppm_whole_q <= cfg_wdata_i[7:0];
          CfgPpmHundred: ppm_hund_q <= cfg_wdata_i[7:0];
          default:       xtal_q <= cfg_wdata_i[25:0];
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (writes_q.size() == 0) begin
          $error("unexpected register write addr=%0d data=%0h",
                 out_data_i.reg_addr, out_data_i.reg_data);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = writes_q.pop_front();
          if (e !== out_data_i) begin
            if (e.reg_addr !== out_data_i.reg_addr)
              $error("reg_addr exp %0d got %0d", e.reg_addr, out_data_i.reg_addr);
            if (e.reg_data !== out_data_i.reg_data)
              $error("reg_data exp %0h got %0h", e.reg_data, out_data_i.reg_data);
            if (e.last !== out_data_i.last)
              $error("last exp %0b got %0b", e.last, out_data_i.last);
            if (e.soft_update !== out_data_i.soft_update)
              $error("soft_update exp %0b got %0b", e.soft_update, out_data_i.soft_update);
            if (e.divider !== out_data_i.divider)
              $error("divider exp %0d got %0d", e.divider, out_data_i.divider);
            if (e.error !== out_data_i.error)
              $error("error exp %0b got %0b", e.error, out_data_i.error);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) plan_request(in_data_i);
    end
  end

endmodule

// ----- verif/tb_clock_synth_frequency_planner.sv -----
// Testbench top: drives requests, configuration and output stalls for the planner.
`timescale 1ns / 1ps

module tb_clock_synth_frequency_planner;
  import cfsp_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_pct = 26;
  int          quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  clock_synth_frequency_planner u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cfsp_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_idx_i(paddr[3:2]),
    .cfg_wdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Random output stall
  always @(negedge clk_i) out_stall <= ($urandom_range(99) < idle_pct);

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // The block stalls after each accept, so the extra
  // falling edge at the end costs nothing and keeps valid from toggling twice
  task automatic send(logic tx, logic [25:0] lo, logic [15:0] rit);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= '{transmit: tx, lo_hz: lo, rit_hz: rit};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    in_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
  endtask

  task automatic rand_request;
    logic [25:0] lo;
    case ($urandom_range(5))
      0: lo = 26'($urandom_range(37500000, 30000000));
      1: lo = 26'($urandom_range(100000, 0));
      2: lo = 26'($urandom_range(33000, 0));
      3: lo = 26'($urandom);
      default: lo = 26'($urandom_range(15000000, 1000000));
    endcase
    if ($urandom_range(3) == 0) lo = lo + 26'($urandom_range(2000)); // small tuning steps
    send($urandom_range(1), lo, 16'($urandom));
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, zero target, soft holds, transmit
    send(1'b0, 26'd0, 16'd0);
    send(1'b0, 26'd100, 16'h8000);
    send(1'b1, 26'd7000000, 16'd0);
    send(1'b1, 26'd7000100, 16'd0);
    send(1'b0, 26'd7000100, 16'h7FFF);
    send(1'b0, 26'd37500000, 16'h7FFF);
    send(1'b0, 26'h3FFFFFF, 16'hFFFF);
    send(1'b0, 26'd1, 16'd0);
    send(1'b0, 26'd50000, 16'd0);
    send(1'b0, 26'd14000000, 16'h8000);
    drain();
    cfg_write(CfgPitch, 32'd4095);
    cfg_write(CfgPpmWhole, 32'h80);
    cfg_write(CfgPpmHundred, 32'h9D);
    cfg_write(CfgXtal, 32'd10000000);
    send(1'b1, 26'd0, 16'd0);
    send(1'b1, 26'd21000000, 16'd0);
    send(1'b0, 26'd21000050, 16'd5);
    send(1'b0, 26'd3, 16'd0);
    drain();
    cfg_write(CfgPitch, 32'd0);
    cfg_write(CfgPpmWhole, 32'd127);
    cfg_write(CfgPpmHundred, 32'd99);
    cfg_write(CfgXtal, 32'd40000000);
    send(1'b1, 26'd0, 16'd0);
    send(1'b0, 26'd10000000, 16'd0);
    send(1'b0, 26'd28000000, 16'd0);
    drain();
    cfg_write(CfgXtal, 32'd0);
    send(1'b0, 26'd7000000, 16'd0);
    drain();

    // Random phases with varied settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_write(CfgPitch, $urandom_range(4095));
      cfg_write(CfgPpmWhole, 32'($urandom));
      cfg_write(CfgPpmHundred, 32'($signed($urandom_range(198)) - 99));
      cfg_write(CfgXtal, ph == 0 ? 32'd25000000 : $urandom_range(40000000, 10000000));
      idle_pct = (ph == 2) ? 0 : 26;
      for (int i = 0; i < 56; i++) rand_request();
    end
    idle_pct = 26;
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- clock_synth_frequency_planner.f -----
src/cfsp_pkg.sv
src/cfsp_divider.sv
src/clock_synth_frequency_planner.sv
verif/cfsp_checker.sv
verif/tb_clock_synth_frequency_planner.sv
